/* sv/rip_pkg.sv */
package rip_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int PHASE_W    = 16;
    localparam int VALUE_W    = 32;
    localparam int ROW_W      = 16;
    localparam int COL_W      = 10;
    localparam int TAU_W      = 17;
    localparam int WIDTH_W    = 11;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_TAU    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [TAU_W-1:0]   TAU_ONE      = 17'h10000;
    localparam logic [TAU_W-1:0]   TAU_RESET    = 17'h10000;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd2;

    // Accumulator: up to four terms of u*2^16 + tau*wrap
    localparam int PROD_W    = 34;
    localparam int ACC_W     = 52;
    // Biased dividend for the floor divide by the term count
    localparam int BIAS_SH   = 34;
    localparam int DIV_W     = 37;
    localparam int QUOT_W    = DIV_W + 1;
    localparam int REM_W     = 3;
    localparam int DIV_CNT_W = 6;
    localparam int CNT_W     = 3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_F0_RD,
        ST_F0_WR,
        ST_P_RD,
        ST_P_LD,
        ST_NB_RD,
        ST_NB_MUL,
        ST_NB_ACC,
        ST_DIV_INIT,
        ST_DIV,
        ST_FINISH,
        ST_EMIT0,
        ST_EMIT1,
        ST_ADV
    } state_t;

    typedef enum logic [1:0] {
        PASS_PIX,
        PASS_FWD,
        PASS_BWD,
        PASS_MAIN
    } pass_t;

    // Term sources: line store left/above/right of the cursor, or held registers
    typedef enum logic [2:0] {
        SRC_LEFT_COL,
        SRC_ABOVE,
        SRC_RIGHT,
        SRC_HELD,
        SRC_LEFTV
    } src_t;

    typedef struct packed {
        logic capture;
        logic ph_write;
        logic ph_read;
        logic ls_read;
        src_t src;
        logic p_from_ph;
        logic acc_clear;
        logic mul;
        logic save_above;
        logic acc_add;
        logic div_start;
        logic ls_write;
        logic ls_wdata_ph;
        logic pix_update;
        logic out_load;
        logic out_sel_above;
        logic advance;
        logic cur_zero;
        logic cur_inc;
        logic cur_dec;
    } cmd_t;

    typedef struct packed {
        logic row_zero;
        logic row_one;
        logic x_zero;
        logic x_one;
        logic x_last;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

/* sv/rip_ram.sv */
module rip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/rip_ctrl.sv */
module rip_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rip_pkg::status_t  status,
    output rip_pkg::cmd_t     cmd
);

    rip_pkg::state_t state_reg, state_next;
    rip_pkg::pass_t  pass_reg, pass_next;
    rip_pkg::src_t   src_reg, src_next;

    logic          first_found, next_found;
    rip_pkg::src_t first_src, next_src;

    function automatic logic src_on(input rip_pkg::src_t s, input rip_pkg::pass_t p,
                                    input logic x0, input logic xl);
        logic on;
        on = 1'b0;
        unique case (p)
            rip_pkg::PASS_FWD: on = (s == rip_pkg::SRC_LEFT_COL);
            rip_pkg::PASS_PIX: begin
                on = (s == rip_pkg::SRC_ABOVE) || ((s == rip_pkg::SRC_RIGHT) && !xl) ||
                     ((s == rip_pkg::SRC_HELD) && !x0) || ((s == rip_pkg::SRC_LEFTV) && !x0);
            end
            default: begin
                on = (s == rip_pkg::SRC_ABOVE) || ((s == rip_pkg::SRC_LEFT_COL) && !x0) ||
                     ((s == rip_pkg::SRC_RIGHT) && !xl);
            end
        endcase
        return on;
    endfunction

    // Lowest enabled source overall, and lowest enabled one above the current
    always_comb begin
        first_found = 1'b0;
        first_src   = rip_pkg::SRC_ABOVE;
        next_found  = 1'b0;
        next_src    = rip_pkg::SRC_ABOVE;
        for (int i = 4; i >= 0; i--) begin
            if (src_on(rip_pkg::src_t'(3'(i)), pass_reg, status.x_zero, status.x_last)) begin
                first_found = 1'b1;
                first_src   = rip_pkg::src_t'(3'(i));
                if (3'(i) > src_reg) begin
                    next_found = 1'b1;
                    next_src   = rip_pkg::src_t'(3'(i));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rip_pkg::ST_IDLE;
            pass_reg  <= rip_pkg::PASS_PIX;
            src_reg   <= rip_pkg::SRC_ABOVE;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            src_reg   <= src_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        src_next   = src_reg;
        cmd        = '0;
        cmd.src    = src_reg;
        s_ready    = 1'b0;

        unique case (state_reg)
            rip_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    pass_next   = rip_pkg::PASS_PIX;
                    state_next  = rip_pkg::ST_DISPATCH;
                end
            end
            rip_pkg::ST_DISPATCH: begin
                if (status.row_zero) begin
                    cmd.ph_write = 1'b1;
                    state_next   = status.x_last ? rip_pkg::ST_F0_RD : rip_pkg::ST_ADV;
                    cmd.cur_zero = status.x_last;
                end else begin
                    cmd.acc_clear = 1'b1;
                    src_next      = first_src;
                    state_next    = rip_pkg::ST_NB_RD;
                end
            end
            rip_pkg::ST_F0_RD: begin
                cmd.ph_read = 1'b1;
                state_next  = rip_pkg::ST_F0_WR;
            end
            rip_pkg::ST_F0_WR: begin
                cmd.ls_write    = 1'b1;
                cmd.ls_wdata_ph = 1'b1;
                if (status.x_last) begin
                    pass_next = rip_pkg::PASS_MAIN;
                end else begin
                    pass_next   = rip_pkg::PASS_FWD;
                    cmd.cur_inc = 1'b1;
                end
                state_next = rip_pkg::ST_P_RD;
            end
            rip_pkg::ST_P_RD: begin
                cmd.ph_read = 1'b1;
                state_next  = rip_pkg::ST_P_LD;
            end
            rip_pkg::ST_P_LD: begin
                cmd.p_from_ph = 1'b1;
                cmd.acc_clear = 1'b1;
                src_next      = first_src;
                state_next    = first_found ? rip_pkg::ST_NB_RD : rip_pkg::ST_DIV_INIT;
            end
            rip_pkg::ST_NB_RD: begin
                cmd.ls_read = 1'b1;
                state_next  = rip_pkg::ST_NB_MUL;
            end
            rip_pkg::ST_NB_MUL: begin
                cmd.mul        = 1'b1;
                cmd.save_above = (pass_reg == rip_pkg::PASS_PIX) &&
                                 (src_reg == rip_pkg::SRC_ABOVE);
                state_next     = rip_pkg::ST_NB_ACC;
            end
            rip_pkg::ST_NB_ACC: begin
                cmd.acc_add = 1'b1;
                if (next_found) begin
                    src_next   = next_src;
                    state_next = rip_pkg::ST_NB_RD;
                end else begin
                    state_next = rip_pkg::ST_DIV_INIT;
                end
            end
            rip_pkg::ST_DIV_INIT: begin
                cmd.div_start = 1'b1;
                state_next    = rip_pkg::ST_DIV;
            end
            rip_pkg::ST_DIV: begin
                if (status.div_last) begin
                    state_next = rip_pkg::ST_FINISH;
                end
            end
            rip_pkg::ST_FINISH: begin
                cmd.ls_write = 1'b1;
                unique case (pass_reg)
                    rip_pkg::PASS_PIX: begin
                        cmd.pix_update = 1'b1;
                        state_next = status.row_one ? rip_pkg::ST_EMIT0 : rip_pkg::ST_EMIT1;
                    end
                    rip_pkg::PASS_FWD: begin
                        if (status.x_last) begin
                            pass_next = rip_pkg::PASS_BWD;
                        end else begin
                            cmd.cur_inc = 1'b1;
                        end
                        state_next = rip_pkg::ST_P_RD;
                    end
                    rip_pkg::PASS_BWD: begin
                        if (status.x_one) begin
                            pass_next    = rip_pkg::PASS_MAIN;
                            cmd.cur_zero = 1'b1;
                        end else begin
                            cmd.cur_dec = 1'b1;
                        end
                        state_next = rip_pkg::ST_P_RD;
                    end
                    default: begin
                        if (status.x_last) begin
                            state_next = rip_pkg::ST_ADV;
                        end else begin
                            cmd.cur_inc = 1'b1;
                            state_next  = rip_pkg::ST_P_RD;
                        end
                    end
                endcase
            end
            rip_pkg::ST_EMIT0: begin
                if (status.out_free) begin
                    cmd.out_load      = 1'b1;
                    cmd.out_sel_above = 1'b1;
                    state_next        = rip_pkg::ST_EMIT1;
                end
            end
            rip_pkg::ST_EMIT1: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = rip_pkg::ST_ADV;
                end
            end
            rip_pkg::ST_ADV: begin
                cmd.advance = 1'b1;
                state_next  = rip_pkg::ST_IDLE;
            end
            default: begin
                state_next = rip_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/rip_dp.sv */
module rip_dp #(
    parameter int MAX_WIDTH = rip_pkg::MAX_WIDTH_DEF,
    localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rip_pkg::cmd_t                       cmd,
    output rip_pkg::status_t                    status,
    input  logic [rip_pkg::TAU_W-1:0]           tau_eff,
    input  logic [ADDR_W-1:0]                   wm1,
    input  logic [rip_pkg::ROW_W-1:0]           hm1,
    input  logic signed [rip_pkg::PHASE_W-1:0]  s_phase_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [rip_pkg::VALUE_W-1:0]  m_unwrapped_phase,
    output logic [rip_pkg::ROW_W-1:0]           m_pixel_row,
    output logic [rip_pkg::COL_W-1:0]           m_pixel_column,
    output logic                                m_last_of_run
);

    localparam int DIV_LAST = rip_pkg::DIV_W - 1;

    logic [ADDR_W-1:0]                  col_reg, cur_reg, x_sat, ls_raddr;
    logic [rip_pkg::ROW_W-1:0]          row_reg;
    logic signed [rip_pkg::PHASE_W-1:0] p_reg;
    logic signed [rip_pkg::ACC_W-1:0]   acc_reg;
    logic [rip_pkg::CNT_W-1:0]          s_reg;
    logic signed [rip_pkg::VALUE_W-1:0] u_reg, u_sel, above_reg, held_reg, left_reg;
    logic signed [rip_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [rip_pkg::DIV_W-1:0]          div_reg;
    logic [rip_pkg::REM_W-1:0]          rem_reg;
    logic [rip_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic                               div_busy_reg;
    logic                               m_valid_reg;
    logic signed [rip_pkg::VALUE_W-1:0] out_val_reg;
    logic [rip_pkg::ROW_W-1:0]          out_row_reg;
    logic [ADDR_W-1:0]                  out_col_reg;
    logic                               out_last_reg;

    logic [rip_pkg::PHASE_W-1:0]        ph_rdata;
    logic [rip_pkg::VALUE_W-1:0]        ls_rdata;
    logic signed [rip_pkg::VALUE_W-1:0] ls_wdata, ph_ext, result;
    logic signed [rip_pkg::PHASE_W-1:0] wrap;
    logic signed [rip_pkg::TAU_W:0]     tau_s;
    logic signed [rip_pkg::ACC_W-1:0]   u_ext, prod_ext, rnd_sum;
    logic signed [rip_pkg::DIV_W-1:0]   q1_ext;
    logic [rip_pkg::REM_W:0]            trial;
    logic signed [rip_pkg::QUOT_W-1:0]  quot;
    logic [ADDR_W+rip_pkg::COL_W-1:0]   col_wide;

    assign x_sat  = (col_reg > wm1) ? wm1 : col_reg;
    assign ph_ext = rip_pkg::VALUE_W'($signed(ph_rdata));

    always_comb begin
        case (cmd.src)
            rip_pkg::SRC_LEFT_COL: ls_raddr = cur_reg - ADDR_W'(1);
            rip_pkg::SRC_RIGHT:    ls_raddr = cur_reg + ADDR_W'(1);
            default:               ls_raddr = cur_reg;
        endcase
        case (cmd.src)
            rip_pkg::SRC_HELD:  u_sel = held_reg;
            rip_pkg::SRC_LEFTV: u_sel = left_reg;
            default:            u_sel = $signed(ls_rdata);
        endcase
    end

    // Phase difference modulo 2^16 read as signed, times gain
    assign wrap      = $signed(p_reg - u_sel[rip_pkg::PHASE_W-1:0]);
    assign tau_s     = $signed({1'b0, tau_eff});
    assign prod_next = tau_s * wrap;

    assign u_ext    = rip_pkg::ACC_W'(u_reg) <<< 16;
    assign prod_ext = rip_pkg::ACC_W'(prod_reg);
    assign rnd_sum  = acc_reg + $signed(rip_pkg::ACC_W'({s_reg, 15'b0}));
    assign q1_ext   = rip_pkg::DIV_W'($signed(rnd_sum[rip_pkg::ACC_W-1:16]));
    assign trial    = {rem_reg, div_reg[rip_pkg::DIV_W-1]};

    // Remove the 2^34 bias left in the quotient, then clamp to 32 bits
    assign quot = $signed({1'b0, div_reg}) - $signed(rip_pkg::QUOT_W'(1) << rip_pkg::BIAS_SH);
    always_comb begin
        if (quot > $signed(rip_pkg::QUOT_W'(32'h7FFF_FFFF))) begin
            result = 32'sh7FFF_FFFF;
        end else if (quot < -$signed(rip_pkg::QUOT_W'(33'h1_0000_0000) >>> 1)) begin
            result = 32'sh8000_0000;
        end else begin
            result = quot[rip_pkg::VALUE_W-1:0];
        end
    end

    assign ls_wdata = cmd.ls_wdata_ph ? ph_ext : result;

    rip_ram #(.WIDTH(rip_pkg::PHASE_W), .DEPTH(MAX_WIDTH)) u_ph_ram (
        .aclk  (aclk),
        .we    (cmd.ph_write),
        .waddr (cur_reg),
        .wdata (p_reg),
        .re    (cmd.ph_read),
        .raddr (cur_reg),
        .rdata (ph_rdata)
    );

    rip_ram #(.WIDTH(rip_pkg::VALUE_W), .DEPTH(MAX_WIDTH)) u_ls_ram (
        .aclk  (aclk),
        .we    (cmd.ls_write),
        .waddr (cur_reg),
        .wdata (ls_wdata),
        .re    (cmd.ls_read),
        .raddr (ls_raddr),
        .rdata (ls_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            held_reg     <= '0;
            left_reg     <= '0;
            div_busy_reg <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.advance) begin
                if (x_sat >= wm1) begin
                    col_reg <= '0;
                    row_reg <= (row_reg >= hm1) ? '0 : row_reg + 16'd1;
                end else begin
                    col_reg <= x_sat + ADDR_W'(1);
                end
            end
            if (cmd.pix_update) begin
                held_reg <= above_reg;
                left_reg <= result;
            end
            if (cmd.div_start) begin
                div_busy_reg <= 1'b1;
                cnt_reg      <= '0;
            end else if (div_busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == rip_pkg::DIV_CNT_W'(DIV_LAST)) begin
                    div_busy_reg <= 1'b0;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cur_reg <= x_sat;
            p_reg   <= s_phase_sample;
        end else if (cmd.cur_zero) begin
            cur_reg <= '0;
        end else if (cmd.cur_inc) begin
            cur_reg <= cur_reg + ADDR_W'(1);
        end else if (cmd.cur_dec) begin
            cur_reg <= cur_reg - ADDR_W'(1);
        end
        if (cmd.p_from_ph) begin
            p_reg <= $signed(ph_rdata);
        end
        if (cmd.acc_clear) begin
            acc_reg <= '0;
            s_reg   <= '0;
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + u_ext + prod_ext;
            s_reg   <= s_reg + 1'b1;
        end
        if (cmd.mul) begin
            u_reg    <= u_sel;
            prod_reg <= prod_next;
        end
        if (cmd.save_above) begin
            above_reg <= $signed(ls_rdata);
        end
        // Restoring divide of the biased, nonnegative dividend by the term count
        if (cmd.div_start) begin
            div_reg <= q1_ext + $signed({s_reg, rip_pkg::BIAS_SH'(0)});
            rem_reg <= '0;
        end else if (div_busy_reg) begin
            if (trial >= {1'b0, s_reg}) begin
                rem_reg <= rip_pkg::REM_W'(trial - {1'b0, s_reg});
                div_reg <= {div_reg[rip_pkg::DIV_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[rip_pkg::REM_W-1:0];
                div_reg <= {div_reg[rip_pkg::DIV_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load) begin
            out_val_reg  <= cmd.out_sel_above ? above_reg : result;
            out_row_reg  <= cmd.out_sel_above ? '0 : row_reg;
            out_col_reg  <= cur_reg;
            out_last_reg <= !cmd.out_sel_above;
        end
    end

    assign col_wide = {{rip_pkg::COL_W{1'b0}}, out_col_reg};

    assign m_valid           = m_valid_reg;
    assign m_unwrapped_phase = out_val_reg;
    assign m_pixel_row       = out_row_reg;
    assign m_pixel_column    = col_wide[rip_pkg::COL_W-1:0];
    assign m_last_of_run     = out_last_reg;

    assign status.row_zero = (row_reg == '0);
    assign status.row_one  = (row_reg == 16'd1);
    assign status.x_zero   = (cur_reg == '0);
    assign status.x_one    = (cur_reg == ADDR_W'(1));
    assign status.x_last   = (cur_reg == wm1);
    assign status.div_last = div_busy_reg && (cnt_reg == rip_pkg::DIV_CNT_W'(DIV_LAST));
    assign status.out_free = !m_valid_reg || m_ready;

`ifndef SYNTHESIS
    a_left_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ls_read && (cmd.src == rip_pkg::SRC_LEFT_COL) |-> cur_reg != '0)
        else $error("left neighbor read at column zero");
    a_right_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ls_read && (cmd.src == rip_pkg::SRC_RIGHT) |-> cur_reg != wm1)
        else $error("right neighbor read past last column");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> (s_reg != '0) && (s_reg <= 3'd4))
        else $error("term count out of range at divide");
    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy_reg |-> {1'b0, rem_reg} < {1'b0, s_reg})
        else $error("divider remainder not below divisor");
    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_valid_reg || m_ready)
        else $error("output register overwritten while held");
`endif

endmodule

/* sv/raster_iir_phase_unwrap.sv */
// Raster IIR phase unwrapper. Wrapped 16-bit phase pixels (2*pi/65536 per LSB)
// enter in raster order on the s_ channel; each pixel becomes the rounded mean,
// over its already-unwrapped 3x3 neighbors, of neighbor + tau * wrap(phase -
// neighbor), saturated to 32 bits. Row 0 is buffered: its last pixel triggers a
// forward, a backward and a main in-place pass over the row, and row-0 results
// come out interleaved with row 1 (row 0 column x, then row 1 column x). Row 0
// pixels give no transaction, row 1 pixels two and later rows one each. The
// block takes one item at a time: a sequencer over a shared multiply/accumulate
// and a 37-step restoring divider. A row-1+ pixel reads its neighbor terms one
// at a time (one to four terms, single line store read port), then divides,
// writes back and emits its results; a result waiting on m_ready holds up the
// next input. A row-0 pixel other than the last is only stored. The last row-0
// pixel runs the three passes, about 3*width elements, before the next input is
// taken. No clearing pass is needed after reset.
module raster_iir_phase_unwrap #(
    parameter int MAX_WIDTH = rip_pkg::MAX_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [rip_pkg::PHASE_W-1:0]    s_phase_sample,
    // Result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [rip_pkg::VALUE_W-1:0]    m_unwrapped_phase,
    output logic [rip_pkg::ROW_W-1:0]             m_pixel_row,
    output logic [rip_pkg::COL_W-1:0]             m_pixel_column,
    output logic                                  m_last_of_run,
    // Config write port
    input  logic                                  cfg_wr_en,
    input  logic [rip_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rip_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    logic [rip_pkg::TAU_W-1:0]   tau_reg, tau_eff;
    logic [rip_pkg::WIDTH_W-1:0] width_reg;
    logic [rip_pkg::ROW_W-1:0]   height_reg, hm1;
    logic [ADDR_W-1:0]           wm1;

    rip_pkg::cmd_t    cmd;
    rip_pkg::status_t status;

    // Config registers; a write takes effect at once, so write only while
    // no transaction is in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tau_reg    <= rip_pkg::TAU_RESET;
            width_reg  <= rip_pkg::WIDTH_RESET;
            height_reg <= rip_pkg::HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rip_pkg::REG_TAU:    tau_reg    <= cfg_data;
                rip_pkg::REG_WIDTH:  width_reg  <= cfg_data[rip_pkg::WIDTH_W-1:0];
                rip_pkg::REG_HEIGHT: height_reg <= cfg_data[rip_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective settings: gain capped at one, width clamped to 1..MAX_WIDTH,
    // height at least two (kept as last index values)
    assign tau_eff = (tau_reg > rip_pkg::TAU_ONE) ? rip_pkg::TAU_ONE : tau_reg;

    always_comb begin
        if (width_reg == '0) begin
            wm1 = '0;
        end else if (32'(width_reg) > MAX_WIDTH) begin
            wm1 = ADDR_W'(MAX_WIDTH - 1);
        end else begin
            wm1 = ADDR_W'(32'(width_reg) - 1);
        end
    end

    assign hm1 = (height_reg < 16'd2) ? 16'd1 : height_reg - 16'd1;

    rip_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rip_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .tau_eff           (tau_eff),
        .wm1               (wm1),
        .hm1               (hm1),
        .s_phase_sample    (s_phase_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_unwrapped_phase (m_unwrapped_phase),
        .m_pixel_row       (m_pixel_row),
        .m_pixel_column    (m_pixel_column),
        .m_last_of_run     (m_last_of_run)
    );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

// Checks raster_iir_phase_unwrap against a cycle-free model of the unwrapping
// filter. The first frame runs at a width of FILL_W pixels, the widest used
// later, so every row-store entry that is ever read has been written. After
// that, a series of register settings are run over frames of small width, and
// these settings include the extremes and the out-of-range values.
module testbench;

    localparam int MAXW   = 1024;
    localparam int FILL_W = 12;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic signed [rip_pkg::PHASE_W-1:0]  s_phase_sample;
    logic                                m_valid;
    logic                                m_ready;
    logic signed [rip_pkg::VALUE_W-1:0]  m_unwrapped_phase;
    logic [rip_pkg::ROW_W-1:0]           m_pixel_row;
    logic [rip_pkg::COL_W-1:0]           m_pixel_column;
    logic                                m_last_of_run;
    logic                                cfg_wr_en;
    logic [rip_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [rip_pkg::CFG_DATA_W-1:0]      cfg_data;

    raster_iir_phase_unwrap DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_phase_sample    (s_phase_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_unwrapped_phase (m_unwrapped_phase),
        .m_pixel_row       (m_pixel_row),
        .m_pixel_column    (m_pixel_column),
        .m_last_of_run     (m_last_of_run),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    typedef struct {
        logic signed [rip_pkg::VALUE_W-1:0] phase;
        logic [rip_pkg::ROW_W-1:0]          row;
        logic [rip_pkg::COL_W-1:0]          col;
        logic                               last;
    } unwrapped_px_t;

    // Model state, same meaning as the block's own registers and stores
    logic [rip_pkg::TAU_W-1:0]           gain;
    logic [rip_pkg::WIDTH_W-1:0]         width_reg;
    logic [rip_pkg::ROW_W-1:0]           height_reg;
    logic signed [31:0]                  unwrapped_line [MAXW];
    logic [15:0]                         row0_raw [MAXW];
    logic signed [31:0]                  left_px;
    logic signed [31:0]                  above_left_px;
    int unsigned                         col_pos;
    int unsigned                         row_pos;

    logic signed [rip_pkg::PHASE_W-1:0]  pending_phases [$];
    unwrapped_px_t                       expected_px [$];
    bit                                  s_taken;
    int                                  idle_pct;
    int                                  mismatches;
    int                                  results_seen;
    int                                  pixels_sent;
    int                                  frames_done;

    // ---------------- filter model ----------------
    function automatic longint wrapped_diff(logic signed [31:0] p, logic signed [31:0] u);
        logic signed [15:0] d;
        d = p[15:0] - u[15:0];
        return longint'(d);
    endfunction

    function automatic longint gain_term(logic signed [31:0] u, logic signed [31:0] p);
        longint g;
        g = (gain > rip_pkg::TAU_ONE) ? 65536 : longint'(gain);
        return longint'(u) * 65536 + g * wrapped_diff(p, u);
    endfunction

    // Round-half-up mean with 32-bit saturation
    function automatic logic signed [31:0] rounded_mean(longint sum, longint cnt);
        longint den, num, q;
        den = cnt * 65536;
        num = sum + cnt * 32768;
        q = num / den;
        if (num % den != 0 && num < 0)
            q--;
        if (q > 64'sd2147483647)
            return 32'sh7fffffff;
        if (q < -64'sd2147483648)
            return 32'sh80000000;
        return q[31:0];
    endfunction

    function automatic int unsigned eff_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAXW)
            return MAXW;
        return width_reg;
    endfunction

    function automatic logic signed [31:0] row0_phase(int unsigned x);
        return {{16{row0_raw[x][15]}}, row0_raw[x]};
    endfunction

    function automatic logic signed [31:0] row0_mean(int unsigned x, int unsigned w);
        longint sum, cnt;
        logic signed [31:0] p;
        p = row0_phase(x);
        sum = gain_term(unwrapped_line[x], p);
        cnt = 1;
        if (x > 0) begin
            sum += gain_term(unwrapped_line[x-1], p);
            cnt++;
        end
        if (x + 1 < w) begin
            sum += gain_term(unwrapped_line[x+1], p);
            cnt++;
        end
        return rounded_mean(sum, cnt);
    endfunction

    // Forward, backward, then main pass over the buffered first row
    function automatic void unwrap_first_row(int unsigned w);
        unwrapped_line[0] = row0_phase(0);
        for (int unsigned x = 1; x < w; x++)
            unwrapped_line[x] = rounded_mean(gain_term(unwrapped_line[x-1], row0_phase(x)), 1);
        for (int unsigned x = w - 1; x > 0; x--)
            unwrapped_line[x] = row0_mean(x, w);
        for (int unsigned x = 0; x < w; x++)
            unwrapped_line[x] = row0_mean(x, w);
    endfunction

    function automatic void unwrap_pixel(logic signed [rip_pkg::PHASE_W-1:0] ph);
        int unsigned w, h, x;
        longint sum, cnt;
        logic signed [31:0] p, v;
        unwrapped_px_t r;
        w = eff_width();
        h = (height_reg < 2) ? 2 : height_reg;
        p = 32'(ph);
        if (col_pos >= w)
            col_pos = w - 1;       // width shrank under the cursor: row ends here
        x = col_pos;
        if (row_pos == 0) begin
            row0_raw[x] = ph;
            if (x == w - 1)
                unwrap_first_row(w);
        end else begin
            sum = gain_term(unwrapped_line[x], p);
            cnt = 1;
            if (x > 0) begin
                sum += gain_term(above_left_px, p) + gain_term(left_px, p);
                cnt += 2;
            end
            if (x + 1 < w) begin
                sum += gain_term(unwrapped_line[x+1], p);
                cnt++;
            end
            v = rounded_mean(sum, cnt);
            if (row_pos == 1) begin
                r.phase = unwrapped_line[x]; r.row = '0; r.col = rip_pkg::COL_W'(x);
                r.last = 1'b0;
                expected_px.insert(expected_px.size(), r);
            end
            r.phase = v; r.row = rip_pkg::ROW_W'(row_pos); r.col = rip_pkg::COL_W'(x);
            r.last = 1'b1;
            expected_px.insert(expected_px.size(), r);
            above_left_px = unwrapped_line[x];
            unwrapped_line[x] = v;
            left_px = v;
        end
        if (x >= w - 1) begin
            col_pos = 0;
            row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
            frames_done += (row_pos == 0);
        end else begin
            col_pos = x + 1;
        end
    endfunction

    // ---------------- clock, reset ----------------
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ---------------- input driver ----------------
    always @(negedge aclk) begin
        if (!s_valid || s_taken) begin
            s_taken = 1'b0;
            if (aresetn && pending_phases.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                s_valid        <= 1'b1;
                s_phase_sample <= pending_phases.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // ---------------- monitor / scoreboard ----------------
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            unwrap_pixel(s_phase_sample);
            pixels_sent++;
            s_taken = 1'b1;
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_px.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected transaction row %0d col %0d value %0d",
                             m_pixel_row, m_pixel_column, m_unwrapped_phase);
            end else begin
                unwrapped_px_t e;
                e = expected_px.pop_front();
                if (m_unwrapped_phase !== e.phase || m_pixel_row !== e.row ||
                    m_pixel_column !== e.col || m_last_of_run !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: exp val %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
                                 e.phase, e.row, e.col, e.last, m_unwrapped_phase,
                                 m_pixel_row, m_pixel_column, m_last_of_run);
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    logic signed [rip_pkg::PHASE_W-1:0] last_phase;

    // Mostly smooth phase with wraps, some noise and some extremes
    function automatic logic signed [rip_pkg::PHASE_W-1:0] next_phase();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            last_phase = last_phase + 16'($urandom_range(0, 12000)) - 16'sd6000;
        else if (pick < 90)
            last_phase = 16'($urandom);
        else
            last_phase = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
        return last_phase;
    endfunction

    task automatic write_reg(logic [rip_pkg::CFG_IDX_W-1:0] idx,
                             logic [rip_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            rip_pkg::REG_TAU:    gain       = val;
            rip_pkg::REG_WIDTH:  width_reg  = val[rip_pkg::WIDTH_W-1:0];
            rip_pkg::REG_HEIGHT: height_reg = val[rip_pkg::ROW_W-1:0];
            default: ;
        endcase
    endtask

    // Drain: all sent, all results back, then cover a possible first-row pass
    task automatic drain();
        int unsigned settle;
        while (pending_phases.size() > 0 || s_valid || expected_px.size() > 0)
            @(posedge aclk);
        settle = 3 * 60 * eff_width() + 300;
        repeat (settle) @(posedge aclk);
    endtask

    task automatic run_phase(int unsigned t, int unsigned w, int unsigned h, int n);
        write_reg(rip_pkg::REG_TAU, rip_pkg::CFG_DATA_W'(t));
        write_reg(rip_pkg::REG_WIDTH, rip_pkg::CFG_DATA_W'(w));
        write_reg(rip_pkg::REG_HEIGHT, rip_pkg::CFG_DATA_W'(h));
        for (int i = 0; i < n; i++)
            pending_phases.insert(pending_phases.size(), next_phase());
        drain();
    endtask

    initial begin
        int unsigned rw;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_phase_sample = '0;
        m_ready   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = rip_pkg::REG_TAU;
        cfg_data  = '0;
        s_taken   = 1'b0;
        idle_pct  = 38;
        mismatches = 0; results_seen = 0; pixels_sent = 0; frames_done = 0;
        last_phase = '0;
        gain = rip_pkg::TAU_RESET; width_reg = rip_pkg::WIDTH_RESET;
        height_reg = rip_pkg::HEIGHT_RESET;
        for (int i = 0; i < MAXW; i++) begin
            unwrapped_line[i] = '0;
            row0_raw[i] = '0;
        end
        left_px = '0; above_left_px = '0; col_pos = 0; row_pos = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset gain and height at the widest width used: fills both stores.
        // Extremes lead row 0, and row 1 stops part way.
        write_reg(rip_pkg::REG_WIDTH, rip_pkg::CFG_DATA_W'(FILL_W));
        pending_phases.insert(pending_phases.size(), 16'sh8000);
        pending_phases.insert(pending_phases.size(), 16'sh7fff);
        pending_phases.insert(pending_phases.size(), 16'sh0000);
        pending_phases.insert(pending_phases.size(), 16'shffff);
        pending_phases.insert(pending_phases.size(), 16'sh0001);
        pending_phases.insert(pending_phases.size(), 16'sh8000);
        for (int i = 6; i < FILL_W + 10; i++)
            pending_phases.insert(pending_phases.size(), next_phase());
        drain();

        // Shrinking width mid-row ends row 1 early; then extreme settings
        run_phase(0, 5, 0, 12);                         // zero gain, height below two
        run_phase(1, 1, 1, 8);                          // single-pixel rows
        run_phase(rip_pkg::TAU_ONE + 1, 0, 2, 8);       // oversize gain, width zero
        run_phase(17'h1ffff, 3, 65535, 12);             // gain max, tall frame
        run_phase(rip_pkg::TAU_ONE, 2, 2, 12);

        // Random settings; one stretch with no idling on either side
        for (int k = 0; k < 12; k++) begin
            idle_pct = (k == 5) ? 0 : 38;
            rw = $urandom_range(2, 10);
            run_phase($urandom_range(0, 65536), rw, $urandom_range(2, 5),
                      rw * $urandom_range(3, 7));
        end

        $display("Sent %0d pixels over %0d frames, checked %0d result transactions",
                 pixels_sent, frames_done, results_seen);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20000000;
        $display("Timeout after %0d result transactions", results_seen);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
